@@ design/awbg_pkg.sv @@
// shared types and constants for the white-balance gain calibration block
package awbg_pkg;

  localparam int GAIN_W  = 26;
  localparam int RATIO_W = 8;
  localparam int MOD_W   = 7;
  localparam int LENS_W  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_CFG = 8;
  localparam int MUL_A_W = 18;

  typedef logic [GAIN_W-1:0]    gain_t;
  typedef logic [RATIO_W-1:0]   ratio_t;
  typedef logic [MOD_W-1:0]     mod_id_t;
  typedef logic [LENS_W-1:0]    lens_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam gain_t UNITY_GAIN = GAIN_W'(1024);
  localparam gain_t RED_TRIM   = GAIN_W'(50);

  localparam mod_id_t MOD_ID_A = 7'h02;
  localparam mod_id_t MOD_ID_B = 7'h15;
  localparam mod_id_t MOD_ID_C = 7'h01;
  localparam lens_t   LENS_ID_D = 8'h03;

  localparam cfg_idx_t CFG_RG_A = 3'd0;
  localparam cfg_idx_t CFG_BG_A = 3'd1;
  localparam cfg_idx_t CFG_RG_B = 3'd2;
  localparam cfg_idx_t CFG_BG_B = 3'd3;
  localparam cfg_idx_t CFG_RG_C = 3'd4;
  localparam cfg_idx_t CFG_BG_C = 3'd5;
  localparam cfg_idx_t CFG_RG_D = 3'd6;
  localparam cfg_idx_t CFG_BG_D = 3'd7;

  localparam ratio_t CFG_RESET [NUM_CFG] = '{
    8'h4b, 8'h4e, 8'h47, 8'h44, 8'h56, 8'h58, 8'h56, 8'h59
  };

  // destination of a finished quotient
  localparam logic [1:0] TGT_R = 2'd0;
  localparam logic [1:0] TGT_G = 2'd1;
  localparam logic [1:0] TGT_B = 2'd2;

endpackage

@@ design/awbg_in_if.sv @@
// calibration record channel
interface awbg_in_if import awbg_pkg::*; ();
  logic    valid;
  logic    ready;
  mod_id_t module_id;
  lens_t   lens_kind;
  ratio_t  measured_rg;
  ratio_t  measured_bg;

  modport source (output valid, module_id, lens_kind, measured_rg, measured_bg,
                  input ready);
  modport sink   (input valid, module_id, lens_kind, measured_rg, measured_bg,
                  output ready);
endinterface

@@ design/awbg_out_if.sv @@
// gain result channel
interface awbg_out_if import awbg_pkg::*; ();
  logic  valid;
  logic  ready;
  gain_t red_gain;
  gain_t green_gain;
  gain_t blue_gain;
  logic  red_write;
  logic  green_write;
  logic  blue_write;
  logic  status;

  modport source (output valid, red_gain, green_gain, blue_gain, red_write,
                  green_write, blue_write, status, input ready);
  modport sink   (input valid, red_gain, green_gain, blue_gain, red_write,
                  green_write, blue_write, status, output ready);
endinterface

@@ design/awbg_cfg_if.sv @@
// golden ratio register write channel
interface awbg_cfg_if import awbg_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  ratio_t   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/awb_gain_from_otp_ratios.sv @@
// top level: white-balance gains from calibration ratios, shared serial divider
//
//   channel   dir  payload                                         accept
//   in_ch     in   module_id, lens_kind, measured_rg, measured_bg  valid & ready
//   out_ch    out  red/green/blue gain, write flags, status        valid & ready
//   cfg_ch    in   index, data (golden ratio registers 0..7)       valid & ready
//
// one word takes two divisions or three divisions from accept to a valid result,
// and the next word can be taken once the sequencer is back in idle
// each division is a load, 26 restoring steps and a store; a zero divisor skips the steps
// in ready only while idle; a result waits in the output register while the
// next word is taken, and the finish step waits if that register is still full
// reset: synchronous, active low; golden registers return to their defaults
module awb_gain_from_otp_ratios import awbg_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  awbg_in_if.sink       in_ch,
  awbg_out_if.source    out_ch,
  awbg_cfg_if.sink      cfg_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [4:0] LAST_BIT = 5'(GAIN_W - 1);

  logic [2:0]  state_r;
  ratio_t      gold_r [NUM_CFG];
  ratio_t      cur_rg_r, cur_bg_r;
  logic        trim_r;
  ratio_t      rg_r, bg_r;
  gain_t       r_r, g_r, b_r;
  logic        bad_r;
  logic [1:0]  step_r;
  logic [1:0]  tgt_r;
  logic        last_r;
  gain_t       num_r;
  ratio_t      den_r;
  ratio_t      rem_r;
  logic [4:0]  cnt_r;
  logic        out_valid_r;
  gain_t       out_r_r, out_g_r, out_b_r;
  logic        out_rw_r, out_gw_r, out_bw_r, out_st_r;

  logic        in_fire, out_fire, fin_fire;
  ratio_t      sel_rg, sel_bg;
  logic        sel_hit, sel_trim;
  logic        bg_lt, rg_lt;
  logic        ld_mul, ld_swap, ld_last;
  logic [1:0]  ld_tgt;
  logic [MUL_A_W-1:0] mul_a;
  ratio_t      mul_b, ld_sh, ld_den;
  gain_t       ld_num;
  logic [RATIO_W:0] trial;
  logic        qbit;
  logic        rw, gw, bw;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;
  assign fin_fire = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  // golden pair selection by module id, and by lens kind for module C
  always_comb begin
    sel_hit  = 1'b1;
    sel_trim = 1'b0;
    sel_rg   = cur_rg_r;
    sel_bg   = cur_bg_r;
    if (in_ch.module_id == MOD_ID_A) begin
      sel_trim = 1'b1;
      sel_rg   = gold_r[CFG_RG_A];
      sel_bg   = gold_r[CFG_BG_A];
    end else if (in_ch.module_id == MOD_ID_B) begin
      sel_rg = gold_r[CFG_RG_B];
      sel_bg = gold_r[CFG_BG_B];
    end else if (in_ch.module_id == MOD_ID_C) begin
      if (in_ch.lens_kind == LENS_ID_D) begin
        sel_rg = gold_r[CFG_RG_D];
        sel_bg = gold_r[CFG_BG_D];
      end else begin
        sel_rg = gold_r[CFG_RG_C];
        sel_bg = gold_r[CFG_BG_C];
      end
    end else begin
      sel_hit = 1'b0;
    end
  end

  assign bg_lt = (bg_r < cur_bg_r);
  assign rg_lt = (rg_r < cur_rg_r);

  // operand plan for the next division
  always_comb begin
    ld_mul  = 1'b0;
    ld_swap = 1'b0;
    ld_last = 1'b0;
    ld_tgt  = TGT_G;
    ld_sh   = bg_r;
    ld_den  = cur_bg_r;
    mul_a   = g_r[MUL_A_W-1:0];
    mul_b   = cur_rg_r;
    case ({bg_lt, rg_lt})
      2'b11: begin
        if (step_r == 2'd0) begin
          ld_sh = cur_bg_r; ld_den = bg_r; ld_tgt = TGT_B;
        end else begin
          ld_sh = cur_rg_r; ld_den = rg_r; ld_tgt = TGT_R; ld_last = 1'b1;
        end
      end
      2'b10: begin
        if (step_r == 2'd0) begin
          ld_sh = rg_r; ld_den = cur_rg_r; ld_tgt = TGT_G;
        end else begin
          ld_mul = 1'b1; mul_b = cur_bg_r; ld_den = bg_r;
          ld_tgt = TGT_B; ld_last = 1'b1;
        end
      end
      2'b01: begin
        if (step_r == 2'd0) begin
          ld_sh = bg_r; ld_den = cur_bg_r; ld_tgt = TGT_G;
        end else begin
          ld_mul = 1'b1; mul_b = cur_rg_r; ld_den = rg_r;
          ld_tgt = TGT_R; ld_last = 1'b1;
        end
      end
      default: begin
        if (step_r == 2'd0) begin
          ld_sh = bg_r; ld_den = cur_bg_r; ld_tgt = TGT_G;
        end else if (step_r == 2'd1) begin
          ld_sh = rg_r; ld_den = cur_rg_r; ld_tgt = TGT_R;
        end else if (g_r > r_r) begin
          ld_mul = 1'b1; mul_b = cur_rg_r; ld_den = rg_r;
          ld_tgt = TGT_R; ld_last = 1'b1;
        end else begin
          ld_mul = 1'b1; ld_swap = 1'b1; mul_a = r_r[MUL_A_W-1:0];
          mul_b = cur_bg_r; ld_den = bg_r; ld_tgt = TGT_B; ld_last = 1'b1;
        end
      end
    endcase
    if (ld_mul) begin
      ld_num = GAIN_W'(mul_a) * GAIN_W'(mul_b);
    end else begin
      ld_num = GAIN_W'({ld_sh, 10'b0});
    end
  end

  // one restoring step
  assign trial = {rem_r, num_r[GAIN_W-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  assign rw = (r_r > UNITY_GAIN);
  assign gw = (g_r > UNITY_GAIN);
  assign bw = (b_r > UNITY_GAIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gold_r <= CFG_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      gold_r[cfg_ch.index] <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_rg_r    <= '0;
      cur_bg_r    <= '0;
      trim_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (sel_hit) begin
              cur_rg_r <= sel_rg;
              cur_bg_r <= sel_bg;
            end
            if (sel_trim) begin
              trim_r <= 1'b1;
            end
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (ld_den == '0) begin
            state_r <= S_STORE;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt_r == LAST_BIT) begin
            state_r <= S_STORE;
          end
        end
        S_STORE: begin
          if (last_r) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_LOAD;
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        rg_r   <= in_ch.measured_rg;
        bg_r   <= in_ch.measured_bg;
        r_r    <= UNITY_GAIN;
        g_r    <= UNITY_GAIN;
        b_r    <= UNITY_GAIN;
        bad_r  <= 1'b0;
        step_r <= 2'd0;
      end
      S_LOAD: begin
        tgt_r  <= ld_tgt;
        last_r <= ld_last;
        den_r  <= ld_den;
        rem_r  <= '0;
        cnt_r  <= '0;
        if (ld_swap) begin
          g_r <= r_r;
          r_r <= UNITY_GAIN;
        end
        if (ld_den == '0) begin
          bad_r <= 1'b1;
          num_r <= '0;
        end else begin
          num_r <= ld_num;
        end
      end
      S_DIV: begin
        if (qbit) begin
          rem_r <= RATIO_W'(trial - {1'b0, den_r});
        end else begin
          rem_r <= trial[RATIO_W-1:0];
        end
        num_r <= {num_r[GAIN_W-2:0], qbit};
        cnt_r <= cnt_r + 5'd1;
      end
      S_STORE: begin
        step_r <= step_r + 2'd1;
        case (tgt_r)
          TGT_R:   r_r <= num_r;
          TGT_B:   b_r <= num_r;
          default: g_r <= num_r;
        endcase
      end
      S_FIN: begin
        if (fin_fire) begin
          if (bad_r) begin
            out_r_r  <= UNITY_GAIN;
            out_g_r  <= UNITY_GAIN;
            out_b_r  <= UNITY_GAIN;
            out_rw_r <= 1'b0;
            out_gw_r <= 1'b0;
            out_bw_r <= 1'b0;
          end else begin
            out_r_r  <= (rw && trim_r) ? (r_r - RED_TRIM) : r_r;
            out_g_r  <= g_r;
            out_b_r  <= b_r;
            out_rw_r <= rw;
            out_gw_r <= gw;
            out_bw_r <= bw;
          end
          out_st_r <= bad_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.red_gain    = out_r_r;
  assign out_ch.green_gain  = out_g_r;
  assign out_ch.blue_gain   = out_b_r;
  assign out_ch.red_write   = out_rw_r;
  assign out_ch.green_write = out_gw_r;
  assign out_ch.blue_write  = out_bw_r;
  assign out_ch.status      = out_st_r;

  // divider never runs on a zero divisor
  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (den_r != '0))
    else $error("divider running with zero divisor");

  // error results carry unity gains and no write flags
  a_bad_unity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r) |-> ((out_r_r == UNITY_GAIN) && (out_g_r == UNITY_GAIN)
      && (out_b_r == UNITY_GAIN) && !out_rw_r && !out_gw_r && !out_bw_r))
    else $error("error result without unity gains");

  // a written red gain stays above unity minus trim
  a_red_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rw_r) |-> (out_r_r > UNITY_GAIN - RED_TRIM))
    else $error("red gain below trim floor");

  // a finished word lands in the output register as a valid result and the sequencer goes idle
  a_fin_slot: assert property (@(posedge clk) disable iff (!rst_n)
    fin_fire |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("result not registered after finish");

endmodule

@@ dv/awb_gain_from_otp_ratios_test.sv @@
// testbench for the white-balance gain calibration block
module awb_gain_from_otp_ratios_test import awbg_pkg::*; ();

  typedef struct packed {
    gain_t red_gain;
    gain_t green_gain;
    gain_t blue_gain;
    logic  red_write;
    logic  green_write;
    logic  blue_write;
    logic  status;
  } gain_word_t;

  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst_n;

  awbg_in_if  in_ch ();
  awbg_out_if out_ch ();
  awbg_cfg_if cfg_ch ();

  awb_gain_from_otp_ratios DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ratio_t     golden_regs [NUM_CFG];
  ratio_t     sel_rg;
  ratio_t     sel_bg;
  bit         trim_on;
  gain_word_t expected_gains [$];
  gain_word_t oldest_gain;
  int         error_count;
  int         send_idle_pct;
  int         recv_idle_pct;
  bit         hold_request;
  int         hold_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned quot(int unsigned num, int unsigned den);
    return (den == 0) ? 0 : num / den;
  endfunction

  function automatic gain_word_t predict_gains(mod_id_t mod_id, lens_t lens, ratio_t rg,
                                               ratio_t bg);
    gain_word_t  w;
    int unsigned unity = UNITY_GAIN;
    int unsigned grg, gbg, r, g, b, gb, gr;
    bit          bad;
    if (mod_id == MOD_ID_A) begin
      trim_on = 1'b1;
      sel_rg = golden_regs[CFG_RG_A];
      sel_bg = golden_regs[CFG_BG_A];
    end else if (mod_id == MOD_ID_B) begin
      sel_rg = golden_regs[CFG_RG_B];
      sel_bg = golden_regs[CFG_BG_B];
    end else if (mod_id == MOD_ID_C) begin
      if (lens == LENS_ID_D) begin
        sel_rg = golden_regs[CFG_RG_D];
        sel_bg = golden_regs[CFG_BG_D];
      end else begin
        sel_rg = golden_regs[CFG_RG_C];
        sel_bg = golden_regs[CFG_BG_C];
      end
    end
    grg = sel_rg;
    gbg = sel_bg;
    if (bg < gbg) begin
      if (rg < grg) begin
        g = unity;
        b = quot(unity * gbg, bg);
        r = quot(unity * grg, rg);
        bad = (bg == 0) || (rg == 0);
      end else begin
        r = unity;
        g = quot(unity * rg, grg);
        b = quot(g * gbg, bg);
        bad = (grg == 0) || (bg == 0);
      end
    end else if (rg < grg) begin
      b = unity;
      g = quot(unity * bg, gbg);
      r = quot(g * grg, rg);
      bad = (gbg == 0) || (rg == 0);
    end else begin
      gb = quot(unity * bg, gbg);
      gr = quot(unity * rg, grg);
      bad = (gbg == 0) || (grg == 0);
      // equal green gains pin red
      if (gb > gr) begin
        b = unity;
        g = gb;
        r = quot(g * grg, rg);
        bad = bad || (rg == 0);
      end else begin
        r = unity;
        g = gr;
        b = quot(g * gbg, bg);
        bad = bad || (bg == 0);
      end
    end
    if (bad) begin
      r = unity;
      g = unity;
      b = unity;
    end
    w.red_write   = (r > unity);
    w.green_write = (g > unity);
    w.blue_write  = (b > unity);
    w.status      = bad;
    if (w.red_write && trim_on) r = r - RED_TRIM;
    w.red_gain   = gain_t'(r);
    w.green_gain = gain_t'(g);
    w.blue_gain  = gain_t'(b);
    return w;
  endfunction

  function automatic ratio_t near_ratio(ratio_t center);
    int v;
    v = int'(center) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return ratio_t'(v);
  endfunction

  task automatic send_record(mod_id_t mod_id, lens_t lens, ratio_t rg, ratio_t bg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.module_id   <= mod_id;
    in_ch.lens_kind   <= lens;
    in_ch.measured_rg <= rg;
    in_ch.measured_bg <= bg;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_gains.push_back(predict_gains(mod_id, lens, rg, bg));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (expected_gains.size() != 0);
  endtask

  task automatic write_golden(cfg_idx_t idx, ratio_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    golden_regs[idx] = val;
    @(negedge clk);
  endtask

  task automatic load_goldens(input ratio_t vals [NUM_CFG]);
    drain_results();
    for (int i = 0; i < NUM_CFG; i++) write_golden(cfg_idx_t'(i), vals[i]);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_random_goldens();
    ratio_t vals [NUM_CFG];
    for (int i = 0; i < NUM_CFG; i++)
      vals[i] = ($urandom_range(15) == 0) ? ratio_t'(0) : ratio_t'($urandom_range(1, 255));
    load_goldens(vals);
  endtask

  task automatic send_random_record();
    int       kind;
    cfg_idx_t base;
    mod_id_t  mod_id;
    lens_t    lens;
    ratio_t   rg;
    ratio_t   bg;
    kind = $urandom_range(9);
    lens = lens_t'($urandom);
    if (kind < 2) begin
      mod_id = MOD_ID_A;
      base = CFG_RG_A;
    end else if (kind < 4) begin
      mod_id = MOD_ID_B;
      base = CFG_RG_B;
    end else if (kind < 7) begin
      mod_id = MOD_ID_C;
      if ($urandom_range(1)) lens = LENS_ID_D;
      base = (lens == LENS_ID_D) ? CFG_RG_D : CFG_RG_C;
    end else begin
      mod_id = mod_id_t'($urandom);
      base = cfg_idx_t'(2 * $urandom_range(3));
    end
    if ($urandom_range(1)) begin
      rg = near_ratio(golden_regs[base]);
      bg = near_ratio(golden_regs[base + cfg_idx_t'(1)]);
    end else begin
      rg = ratio_t'($urandom);
      bg = ratio_t'($urandom);
    end
    send_record(mod_id, lens, rg, bg);
  endtask

  // default goldens, zero divisors before any known module, trim off then on
  task automatic test_reset_goldens();
    send_record(7'h7f, 8'h00, 8'd255, 8'd255);
    send_record(7'h00, 8'hff, 8'd0, 8'd0);
    send_record(MOD_ID_C, 8'h00, 8'd86, 8'd88);
    send_record(MOD_ID_C, LENS_ID_D, 8'd40, 8'd200);
    send_record(MOD_ID_C, 8'h02, 8'd255, 8'd255);
    send_record(MOD_ID_C, LENS_ID_D, 8'd255, 8'd255);
    send_record(MOD_ID_B, 8'h03, 8'd0, 8'd100);
    send_record(MOD_ID_B, 8'h00, 8'd255, 8'd0);
    send_record(MOD_ID_B, 8'h00, 8'd1, 8'd1);
    send_record(7'h40, 8'haa, 8'd255, 8'd255);
    send_record(MOD_ID_B, 8'h55, 8'd255, 8'd1);
    send_record(MOD_ID_B, 8'h00, 8'd1, 8'd255);
    send_record(MOD_ID_B, 8'h03, 8'd128, 8'd127);
    send_record(MOD_ID_A, 8'hff, 8'd10, 8'd10);
    send_record(MOD_ID_A, 8'h00, 8'd75, 8'd78);
    send_record(MOD_ID_A, 8'h00, 8'd74, 8'd78);
    send_record(MOD_ID_A, 8'h00, 8'd75, 8'd77);
    send_record(7'h7f, 8'hff, 8'd0, 8'd0);
    send_record(7'h03, 8'h03, 8'd100, 8'd100);
  endtask

  // largest gains and zero goldens
  task automatic test_golden_extremes();
    load_goldens('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
    send_record(MOD_ID_A, 8'h00, 8'd255, 8'd255);
    send_record(MOD_ID_B, 8'h00, 8'd1, 8'd1);
    send_record(MOD_ID_C, LENS_ID_D, 8'd0, 8'd254);
    load_goldens('{8'd255, 8'd1, 8'd1, 8'd255, 8'd0, 8'd0, 8'd128, 8'd127});
    send_record(MOD_ID_A, 8'h00, 8'd1, 8'd255);
    send_record(MOD_ID_B, 8'h00, 8'd255, 8'd1);
    send_record(MOD_ID_C, 8'h00, 8'd200, 8'd200);
    send_record(MOD_ID_C, LENS_ID_D, 8'd200, 8'd200);
    load_goldens('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    send_record(7'h40, 8'h00, 8'd5, 8'd5);
    send_record(MOD_ID_A, 8'h00, 8'd5, 8'd5);
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int chunk = 0; chunk < 4; chunk++) begin
      load_random_goldens();
      for (int i = 0; i < count / 4; i++) send_random_record();
    end
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    for (int i = 0; i < 20; i++) send_random_record();
  endtask

  task automatic test_sender_pause();
    for (int i = 0; i < 10; i++) send_random_record();
    drain_results();
    for (int i = 0; i < 10; i++) send_random_record();
  endtask

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_gains.size() == 0) begin
        $error("unexpected result word");
        error_count++;
      end else begin
        oldest_gain = expected_gains.pop_front();
        if (out_ch.red_gain !== oldest_gain.red_gain) begin
          $error("red_gain expected %0d got %0d", oldest_gain.red_gain, out_ch.red_gain);
          error_count++;
        end
        if (out_ch.green_gain !== oldest_gain.green_gain) begin
          $error("green_gain expected %0d got %0d", oldest_gain.green_gain,
                 out_ch.green_gain);
          error_count++;
        end
        if (out_ch.blue_gain !== oldest_gain.blue_gain) begin
          $error("blue_gain expected %0d got %0d", oldest_gain.blue_gain, out_ch.blue_gain);
          error_count++;
        end
        if (out_ch.red_write !== oldest_gain.red_write) begin
          $error("red_write expected %0d got %0d", oldest_gain.red_write, out_ch.red_write);
          error_count++;
        end
        if (out_ch.green_write !== oldest_gain.green_write) begin
          $error("green_write expected %0d got %0d", oldest_gain.green_write,
                 out_ch.green_write);
          error_count++;
        end
        if (out_ch.blue_write !== oldest_gain.blue_write) begin
          $error("blue_write expected %0d got %0d", oldest_gain.blue_write,
                 out_ch.blue_write);
          error_count++;
        end
        if (out_ch.status !== oldest_gain.status) begin
          $error("status expected %0d got %0d", oldest_gain.status, out_ch.status);
          error_count++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.module_id = '0;
    in_ch.lens_kind = '0;
    in_ch.measured_rg = '0;
    in_ch.measured_bg = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    error_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b0;
    hold_left = 0;
    golden_regs = '{8'd75, 8'd78, 8'd71, 8'd68, 8'd86, 8'd88, 8'd86, 8'd89};
    sel_rg = '0;
    sel_bg = '0;
    trim_on = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_goldens();
    test_golden_extremes();
    test_random_traffic(21, 61, 320);
    test_output_backpressure();
    test_random_traffic(61, 21, 320);
    test_sender_pause();
    test_random_traffic(0, 0, 320);

    drain_results();
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_gains.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
